@@ rtl/core/trpd_pkg.sv @@
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared types and constants of the TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int PALETTE_DEPTH = 256;

  localparam int DIM_W  = 13;                       // width of the dimension registers
  localparam int POS_W  = $clog2(MAX_WIDTH);        // column / row position
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);    // palette address bits
  localparam int CFG_IW = 3;                        // register index bits
  localparam int CFG_DW = 13;                       // widest register

  // actions
  localparam logic [1:0] ACT_DATA  = 2'd0;
  localparam logic [1:0] ACT_PAL   = 2'd1;
  localparam logic [1:0] ACT_FRAME = 2'd2;

  // depth modes
  localparam logic [1:0] DEPTH_PAL8  = 2'd0;
  localparam logic [1:0] DEPTH_BGR24 = 2'd1;
  localparam logic [1:0] DEPTH_BGRA  = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_DEPTH      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_COMPRESSED = 3'd1;
  localparam logic [CFG_IW-1:0] REG_TOP_DOWN   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WIDTH      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_HEIGHT     = 3'd4;

  localparam logic [7:0] PKT_RUN_BIT   = 8'h80;
  localparam logic [7:0] PKT_LEN_MASK  = 8'h7f;
  localparam logic [7:0] ALPHA_OPAQUE  = 8'hff;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel_color;
    logic [23:0] pixel_address;
    logic [7:0]  run_length;
    logic        frame_end;
  } out_word_t;

endpackage

@@ rtl/core/tga_rle_pixel_decoder_top.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_top
// Decodes a TGA pixel-data byte stream (plain or run-length) into ARGB words
// with a frame address and a fill count.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction | word
//  --------+------------------------------------+-----------+----------------
//  input   | in_valid, in_stall, in_word        | in        | in_word_t
//  result  | out_valid, out_stall, out_word     | out       | out_word_t
//  config  | cfg_we, cfg_index, cfg_wdata       | in        | 13-bit data
//
//  One input word is taken every cycle unless in_stall is high. The byte that
//  completes a pixel is registered in stage 1 along with the synchronous
//  palette read; the address multiply then feeds the output register.
//  Reset (rst_n, synchronous) clears the packet and position state and loads
//  the register defaults; the palette RAM holds nothing until written.
//  out_stall backs up through the two result stages into in_stall; a stage
//  moves on as soon as the one ahead of it empties.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_top
  import trpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // configuration registers
  logic [1:0]       depth_r;
  logic             cmp_r;
  logic             top_down_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;

  // decoder state
  logic [23:0]      byte_buf_r,  byte_buf_nxt;
  logic [1:0]       byte_cnt_r,  byte_cnt_nxt;
  logic [7:0]       pkt_rem_r,   pkt_rem_nxt;
  logic             pkt_run_r,   pkt_run_nxt;
  logic [POS_W-1:0] col_r,       col_nxt;
  logic [POS_W-1:0] row_r,       row_nxt;
  logic             fin_r,       fin_nxt;

  // palette RAM
  logic [23:0]      pal_mem [PALETTE_DEPTH];
  logic [23:0]      pal_q_r;

  // stage 1: pixel waiting for palette data and address
  logic             s1_valid_r;
  logic             s1_is_pal_r;
  logic             s1_pal_ok_r;
  logic [31:0]      s1_color_r;
  logic [POS_W-1:0] s1_row_r;
  logic [POS_W-1:0] s1_col_r;
  logic [DIM_W-1:0] s1_w_r;
  logic [7:0]       s1_count_r;
  logic             s1_fin_r;

  // output register
  logic             out_valid_r;
  out_word_t        out_word_r;

  // combinational
  logic             acc;
  logic             out_free;
  logic             s1_take;
  logic             pix_go;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [2:0]       need;
  logic [31:0]      color_c;
  logic [7:0]       count_c;
  logic [POS_W-1:0] srow_c;
  logic             fin_c;
  logic [DIM_W-1:0] room;
  logic [DIM_W-1:0] col_sum;
  logic [31:0]      shifted;
  logic [23:0]      addr_full;

  // Hand-shake: each stage advances when the one ahead is free
  assign out_free = !out_valid_r || !out_stall;
  assign s1_take  = !s1_valid_r || out_free;
  assign in_stall = !s1_take;
  assign acc      = in_valid && s1_take;

  // Saturate the dimensions into 1..MAX
  always_comb begin
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Bytes per pixel; mode three decodes as 24-bit
  always_comb begin
    case (depth_r)
      DEPTH_PAL8: need = 3'd1;
      DEPTH_BGRA: need = 3'd4;
      default:    need = 3'd3;
    endcase
  end

  assign shifted = 32'(in_word.data_byte) << {byte_cnt_r, 3'b000};
  assign room    = w_eff - DIM_W'(col_r);

  // Packet, pixel and position update for one accepted word
  always_comb begin
    byte_buf_nxt = byte_buf_r;
    byte_cnt_nxt = byte_cnt_r;
    pkt_rem_nxt  = pkt_rem_r;
    pkt_run_nxt  = pkt_run_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    fin_nxt      = fin_r;
    pix_go       = 1'b0;
    color_c      = '0;
    count_c      = 8'd1;
    fin_c        = 1'b0;
    col_sum      = DIM_W'(col_r) + DIM_W'(1);
    srow_c       = top_down_r ? row_r : POS_W'(h_eff - DIM_W'(1) - DIM_W'(row_r));

    if (acc) begin
      case (in_word.action)
        ACT_FRAME: begin
          byte_buf_nxt = '0;
          byte_cnt_nxt = '0;
          pkt_rem_nxt  = '0;
          pkt_run_nxt  = 1'b0;
          col_nxt      = '0;
          row_nxt      = '0;
          fin_nxt      = 1'b0;
        end
        ACT_DATA: begin
          if (!fin_r) begin
            if (cmp_r && pkt_rem_r == '0) begin
              // packet header: record kind and length
              pkt_run_nxt  = |(in_word.data_byte & PKT_RUN_BIT);
              pkt_rem_nxt  = (in_word.data_byte & PKT_LEN_MASK) + 8'd1;
              byte_cnt_nxt = '0;
              byte_buf_nxt = '0;
            end else if (3'(byte_cnt_r) + 3'd1 < need) begin
              // gather a colour byte
              byte_buf_nxt = byte_buf_r | shifted[23:0];
              byte_cnt_nxt = byte_cnt_r + 2'd1;
            end else begin
              pix_go       = 1'b1;
              byte_buf_nxt = '0;
              byte_cnt_nxt = '0;
              case (depth_r)
                DEPTH_PAL8: color_c = {ALPHA_OPAQUE, 24'h0};
                DEPTH_BGRA: color_c = {in_word.data_byte, byte_buf_r};
                default:    color_c = {ALPHA_OPAQUE, in_word.data_byte, byte_buf_r[15:0]};
              endcase
              if (cmp_r && pkt_run_r) begin
                // clip the run at the row end
                count_c     = (DIM_W'(pkt_rem_r) < room) ? pkt_rem_r : room[7:0];
                pkt_rem_nxt = '0;
              end else if (cmp_r) begin
                pkt_rem_nxt = pkt_rem_r - 8'd1;
              end
              col_sum = DIM_W'(col_r) + DIM_W'(count_c);
              if (col_sum >= w_eff) begin
                col_nxt = '0;
                if (DIM_W'(row_r) + DIM_W'(1) >= h_eff) begin
                  row_nxt = '0;
                  fin_nxt = 1'b1;
                  fin_c   = 1'b1;
                end else begin
                  row_nxt = row_r + POS_W'(1);
                end
              end else begin
                col_nxt = col_sum[POS_W-1:0];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Config writes and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= DEPTH_BGRA;
      cmp_r      <= 1'b1;
      top_down_r <= 1'b0;
      width_r    <= DIM_W'(640);
      height_r   <= DIM_W'(480);
      byte_buf_r <= '0;
      byte_cnt_r <= '0;
      pkt_rem_r  <= '0;
      pkt_run_r  <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
      fin_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEPTH:      depth_r    <= cfg_wdata[1:0];
          REG_COMPRESSED: cmp_r      <= cfg_wdata[0];
          REG_TOP_DOWN:   top_down_r <= cfg_wdata[0];
          REG_WIDTH:      width_r    <= cfg_wdata;
          REG_HEIGHT:     height_r   <= cfg_wdata;
          default: ;
        endcase
      end
      byte_buf_r <= byte_buf_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      pkt_rem_r  <= pkt_rem_nxt;
      pkt_run_r  <= pkt_run_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      fin_r      <= fin_nxt;
    end
  end

  // Palette RAM: write on a palette word, read at the data byte on every accept
  always_ff @(posedge clk) begin
    if (acc && in_word.action == ACT_PAL &&
        9'(in_word.palette_index) < 9'(PALETTE_DEPTH)) begin
      pal_mem[in_word.palette_index[PAL_AW-1:0]] <= in_word.palette_color;
    end
    if (acc) begin
      pal_q_r <= pal_mem[in_word.data_byte[PAL_AW-1:0]];
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_take) begin
      s1_valid_r <= pix_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_is_pal_r <= (depth_r == DEPTH_PAL8);
      s1_pal_ok_r <= 9'(in_word.data_byte) < 9'(PALETTE_DEPTH);
      s1_color_r  <= color_c;
      s1_row_r    <= srow_c;
      s1_col_r    <= col_r;
      s1_w_r      <= w_eff;
      s1_count_r  <= count_c;
      s1_fin_r    <= fin_c;
    end
  end

  // Output register: merge palette data, form row * width + column
  assign addr_full = 24'(s1_row_r * s1_w_r) + 24'(s1_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_word_r.pixel_color   <= s1_is_pal_r ?
                                  {ALPHA_OPAQUE, (s1_pal_ok_r ? pal_q_r : 24'h0)} :
                                  s1_color_r;
      out_word_r.pixel_address <= addr_full;
      out_word_r.run_length    <= s1_count_r;
      out_word_r.frame_end     <= s1_fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
